@@ src/assert_macros.svh @@
// Assertion macros used by the line maze path solver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LMPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LMPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/lmps_pkg.sv @@
// Types, codes and helper functions of the line maze path solver.
`default_nettype none

package lmps_pkg;

  localparam int LVL_W = 10;

  typedef logic [LVL_W-1:0] level_t;
  typedef logic [2:0]       cmd_t;
  typedef logic [2:0]       code_t;
  typedef logic [2:0]       cfg_idx_t;

  localparam level_t THR_RESET = 10'd512;

  // Motor commands
  localparam cmd_t CMD_STRAIGHT   = 3'd0;
  localparam cmd_t CMD_LEFT       = 3'd1;
  localparam cmd_t CMD_RIGHT      = 3'd2;
  localparam cmd_t CMD_SOFT_LEFT  = 3'd3;
  localparam cmd_t CMD_SOFT_RIGHT = 3'd4;
  localparam cmd_t CMD_UTURN      = 3'd5;
  localparam cmd_t CMD_STOP       = 3'd6;
  localparam cmd_t CMD_HOLD       = 3'd7;

  // Path store entry codes
  localparam code_t CODE_EMPTY    = 3'd0;
  localparam code_t CODE_BACK     = 3'd1;
  localparam code_t CODE_LEFT     = 3'd2;
  localparam code_t CODE_RIGHT    = 3'd3;
  localparam code_t CODE_STRAIGHT = 3'd4;

  // Configuration register indexes
  localparam cfg_idx_t CFG_FRONT_THR  = 3'd0;
  localparam cfg_idx_t CFG_LEFT_THR   = 3'd1;
  localparam cfg_idx_t CFG_CENTER_THR = 3'd2;
  localparam cfg_idx_t CFG_RIGHT_THR  = 3'd3;
  localparam cfg_idx_t CFG_END_THR    = 3'd4;
  localparam cfg_idx_t CFG_RUN_MODE   = 3'd5;

  // What the back end has to do with a request
  typedef enum logic [2:0] {
    OP_START,
    OP_CMD,
    OP_END,
    OP_DEAD_FINAL,
    OP_REC,
    OP_REPLAY
  } op_t;

  typedef struct packed {
    op_t   op;
    cmd_t  cmd;
    code_t code;
    logic  reduce;
  } item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RD_MID,
    BK_RD_FIRST,
    BK_WR_MID,
    BK_WR_LAST,
    BK_REPLAY
  } bk_state_t;

  typedef struct packed {
    logic  hit;
    code_t code;
  } fold_t;

  // Three-entry path reduction around a back entry
  function automatic fold_t reduce_rule(code_t first, code_t last);
    fold_t f;
    f.hit  = 1'b1;
    f.code = CODE_EMPTY;
    priority if (first == CODE_LEFT && last == CODE_RIGHT) begin
      f.code = CODE_BACK;
    end else if (first == CODE_LEFT && last == CODE_STRAIGHT) begin
      f.code = CODE_RIGHT;
    end else if (first == CODE_LEFT && last == CODE_LEFT) begin
      f.code = CODE_STRAIGHT;
    end else if (first == CODE_STRAIGHT && last == CODE_LEFT) begin
      f.code = CODE_RIGHT;
    end else if (first == CODE_STRAIGHT && last == CODE_STRAIGHT) begin
      f.code = CODE_BACK;
    end else if (first == CODE_RIGHT && last == CODE_LEFT) begin
      f.code = CODE_BACK;
    end else begin
      f.hit = 1'b0;
    end
    return f;
  endfunction

  function automatic cmd_t replay_cmd(code_t c);
    cmd_t m;
    priority if (c == CODE_LEFT) begin
      m = CMD_LEFT;
    end else if (c == CODE_STRAIGHT) begin
      m = CMD_STRAIGHT;
    end else if (c == CODE_RIGHT) begin
      m = CMD_RIGHT;
    end else begin
      m = CMD_HOLD;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ src/lmps_if.sv @@
// Valid/ready channel interfaces for sensor requests and solver results.
`default_nettype none

interface lmps_in_if;
  import lmps_pkg::*;
  logic   valid;
  logic   ready;
  logic   func;
  level_t front_level;
  level_t left_level;
  level_t center_level;
  level_t right_level;
  level_t end_level;

  modport source (output valid, func, front_level, left_level, center_level,
                  right_level, end_level, input ready);
  modport sink (input valid, func, front_level, left_level, center_level,
                right_level, end_level, output ready);
endinterface

interface lmps_out_if #(parameter int CNT_W = 9);
  import lmps_pkg::*;
  logic             valid;
  logic             ready;
  cmd_t             motor_cmd;
  logic [CNT_W-1:0] path_length;
  logic             at_end;
  logic             path_overflow;

  modport source (output valid, motor_cmd, path_length, at_end, path_overflow,
                  input ready);
  modport sink (input valid, motor_cmd, path_length, at_end, path_overflow,
                output ready);
endinterface

`default_nettype wire

@@ src/line_maze_path_solver_core.sv @@
// Top level of the line maze path solver: front end, request queue and path sequencer.
//
//   channel  dir  handshake        contents
//   in_ch    in   valid/ready      func, four sensor levels, end level
//   out_ch   out  valid/ready      motor_cmd, path_length, at_end, path_overflow
//   cfg_*    in   cfg_we only      cfg_idx selects register, cfg_wdata value
//
// Plain commands, start, end, dead ends and records without reduction check are handled by
// the sequencer in its idle state; a final-run replay first reads its entry; a trial junction
// record is stretched by the single path store port (up to two entry reads, up to three writes).
// in_ch takes a request every cycle while the two-entry queue has room.
// rst_n (synchronous) sets thresholds to 512, trial mode and count 0; the store is kept.
// out_ch.ready low holds the result register, then the sequencer, then in_ch.ready.
`default_nettype none
`include "assert_macros.svh"

module line_maze_path_solver_core #(
  parameter int PATH_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  lmps_in_if.sink           in_ch,
  lmps_out_if.source        out_ch,
  input  logic              cfg_we,
  input  lmps_pkg::cfg_idx_t cfg_idx,
  input  lmps_pkg::level_t  cfg_wdata
);
  import lmps_pkg::*;

  localparam int CNT_W = $clog2(PATH_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PATH_DEPTH);

  logic  push_valid, push_ready, q_valid, q_pop;
  item_t push_item, q_item;

  lmps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  lmps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  lmps_back #(
    .PATH_DEPTH (PATH_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item),
    .out_ch  (out_ch)
  );

  `LMPS_ASSERT_IMP(a_len_bound, out_ch.valid, out_ch.path_length <= DEPTH_C, "path length past depth")
  `LMPS_ASSERT_IMP(a_end_stop, out_ch.valid && out_ch.at_end, out_ch.motor_cmd == CMD_STOP && !out_ch.path_overflow, "end without stop")
  `LMPS_ASSERT_IMP(a_ovf_full, out_ch.valid && out_ch.path_overflow, out_ch.path_length == DEPTH_C, "overflow below depth")
  `LMPS_ASSERT_NXT(a_queue_hold, q_valid && !push_ready, q_valid, "full queue emptied in one cycle")

endmodule

`default_nettype wire

@@ src/lmps_front.sv @@
// Front end: threshold registers, sensor pattern decode and request classification.
`default_nettype none

module lmps_front (
  input  logic              clk,
  input  logic              rst_n,
  lmps_in_if.sink           in_ch,
  input  logic              cfg_we,
  input  lmps_pkg::cfg_idx_t cfg_idx,
  input  lmps_pkg::level_t  cfg_wdata,
  output logic              push_valid,
  input  logic              push_ready,
  output lmps_pkg::item_t   push_item
);
  import lmps_pkg::*;

  level_t fthr_r, lthr_r, cthr_r, rthr_r, ethr_r;
  logic   run_mode_r;
  logic [3:0] pat;

  function automatic item_t junction(logic mode, code_t c, cmd_t m);
    item_t it;
    it.op     = mode ? OP_REPLAY : OP_REC;
    it.cmd    = mode ? CMD_HOLD : m;
    it.code   = c;
    it.reduce = 1'b1;
    return it;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fthr_r     <= THR_RESET;
      lthr_r     <= THR_RESET;
      cthr_r     <= THR_RESET;
      rthr_r     <= THR_RESET;
      ethr_r     <= THR_RESET;
      run_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FRONT_THR:  fthr_r     <= cfg_wdata;
        CFG_LEFT_THR:   lthr_r     <= cfg_wdata;
        CFG_CENTER_THR: cthr_r     <= cfg_wdata;
        CFG_RIGHT_THR:  rthr_r     <= cfg_wdata;
        CFG_END_THR:    ethr_r     <= cfg_wdata;
        CFG_RUN_MODE:   run_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Front, left, center, right; 1 = black
  assign pat = {in_ch.front_level >= fthr_r, in_ch.left_level >= lthr_r,
                in_ch.center_level >= cthr_r, in_ch.right_level >= rthr_r};

  always_comb begin
    push_item.op     = OP_CMD;
    push_item.cmd    = CMD_STRAIGHT;
    push_item.code   = CODE_EMPTY;
    push_item.reduce = 1'b0;
    if (in_ch.func) begin
      push_item.op  = OP_START;
      push_item.cmd = CMD_HOLD;
    end else begin
      unique case (pat)
        4'h5: push_item.cmd = CMD_STRAIGHT;
        4'h9: push_item.cmd = CMD_LEFT;
        4'hC: push_item.cmd = CMD_RIGHT;
        4'hB, 4'hD: push_item.cmd = CMD_SOFT_LEFT;
        4'hE: push_item.cmd = CMD_SOFT_RIGHT;
        4'hF: begin
          // dead end: record back in the trial run, skip an entry in the final run
          push_item.op   = run_mode_r ? OP_DEAD_FINAL : OP_REC;
          push_item.cmd  = CMD_UTURN;
          push_item.code = CODE_BACK;
        end
        4'h8, 4'h1: push_item = junction(run_mode_r, CODE_LEFT, CMD_LEFT);
        4'h4: push_item = junction(run_mode_r, CODE_STRAIGHT, CMD_STRAIGHT);
        4'h0: begin
          if (in_ch.end_level >= ethr_r) begin
            push_item.op  = OP_END;
            push_item.cmd = CMD_STOP;
          end else begin
            push_item = junction(run_mode_r, CODE_LEFT, CMD_LEFT);
          end
        end
        default: push_item.cmd = CMD_STRAIGHT;
      endcase
    end
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

`default_nettype wire

@@ src/lmps_queue.sv @@
// Two-entry request queue between the front end and the path sequencer.
`default_nettype none

module lmps_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  lmps_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop,
  output lmps_pkg::item_t pop_item
);
  import lmps_pkg::*;

  localparam int QD = 2;
  localparam int QC_W = $clog2(QD + 1);

  item_t           ent_r [QD];
  logic            wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0] cnt_r;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != QC_W'(QD));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QC_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_item;
  end

endmodule

`default_nettype wire

@@ src/lmps_back.sv @@
// Back end: path store, junction count, record/reduce/replay sequencer and result register.
`default_nettype none

module lmps_back #(
  parameter int PATH_DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_pop,
  input  lmps_pkg::item_t q_item,
  lmps_out_if.source      out_ch
);
  import lmps_pkg::*;

  localparam int CNT_W = $clog2(PATH_DEPTH + 1);
  localparam int AW    = $clog2(PATH_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PATH_DEPTH);
  localparam logic [CNT_W-1:0] TWO_C   = CNT_W'(2);

  bk_state_t        state_r, state_nxt;
  item_t            op_r, cur;
  logic             op_ld;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_p1, cnt_m1, cnt_m2;
  logic             full, needs_rd;

  code_t            mem [PATH_DEPTH];
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  code_t            rd_data_r, wr_data;
  fold_t            fold;

  logic             out_free, res_ld, res_end, res_ovf;
  cmd_t             res_cmd;
  logic             out_valid_r, at_end_r, ovf_r;
  cmd_t             cmd_r;
  logic [CNT_W-1:0] plen_r;

  assign cur      = (state_r == BK_IDLE) ? q_item : op_r;
  assign full     = (cnt_r >= DEPTH_C);
  assign cnt_p1   = cnt_r + CNT_W'(1);
  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign cnt_m2   = cnt_r - TWO_C;
  assign needs_rd = cur.reduce && (cnt_r >= TWO_C) && !full;
  assign fold     = reduce_rule(rd_data_r, op_r.code);
  assign out_free = !out_valid_r || out_ch.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (cur.op == OP_REC && needs_rd) begin
            state_nxt = BK_RD_MID;
          end else if (cur.op == OP_REPLAY && !full) begin
            state_nxt = BK_REPLAY;
          end
        end
      end
      BK_RD_MID: begin
        if (rd_data_r == CODE_BACK) begin
          state_nxt = BK_RD_FIRST;
        end else if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_RD_FIRST: begin
        if (fold.hit) begin
          state_nxt = BK_WR_MID;
        end else if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_WR_MID:  state_nxt = BK_WR_LAST;
      BK_WR_LAST: if (out_free) state_nxt = BK_IDLE;
      BK_REPLAY:  if (out_free) state_nxt = BK_IDLE;
      default:    state_nxt = BK_IDLE;
    endcase
  end

  // Outputs: memory port, queue pop, count update, result load
  always_comb begin
    q_pop   = 1'b0;
    op_ld   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = cnt_r[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = cnt_r[AW-1:0];
    wr_data = cur.code;
    res_ld  = 1'b0;
    res_cmd = cur.cmd;
    res_end = 1'b0;
    res_ovf = 1'b0;
    cnt_nxt = cnt_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          unique case (cur.op)
            OP_START: begin
              if (out_free) begin
                q_pop   = 1'b1;
                res_ld  = 1'b1;
                res_cmd = CMD_HOLD;
                cnt_nxt = '0;
              end
            end
            OP_END: begin
              if (out_free) begin
                q_pop   = 1'b1;
                res_ld  = 1'b1;
                res_cmd = CMD_STOP;
                res_end = 1'b1;
              end
            end
            OP_DEAD_FINAL: begin
              if (out_free) begin
                q_pop   = 1'b1;
                res_ld  = 1'b1;
                res_cmd = CMD_UTURN;
                if (!full) cnt_nxt = cnt_p1;
              end
            end
            OP_REC: begin
              if (full) begin
                // drop the record, keep the command
                if (out_free) begin
                  q_pop   = 1'b1;
                  res_ld  = 1'b1;
                  res_ovf = 1'b1;
                end
              end else if (needs_rd) begin
                q_pop   = 1'b1;
                op_ld   = 1'b1;
                rd_en   = 1'b1;
                rd_addr = cnt_m1[AW-1:0];
              end else if (out_free) begin
                q_pop   = 1'b1;
                res_ld  = 1'b1;
                wr_en   = 1'b1;
                cnt_nxt = cnt_p1;
              end
            end
            OP_REPLAY: begin
              if (full) begin
                if (out_free) begin
                  q_pop   = 1'b1;
                  res_ld  = 1'b1;
                  res_cmd = CMD_HOLD;
                end
              end else begin
                q_pop = 1'b1;
                op_ld = 1'b1;
                rd_en = 1'b1;
              end
            end
            default: begin
              if (out_free) begin
                q_pop  = 1'b1;
                res_ld = 1'b1;
              end
            end
          endcase
        end
      end
      BK_RD_MID: begin
        if (rd_data_r == CODE_BACK) begin
          rd_en   = 1'b1;
          rd_addr = cnt_m2[AW-1:0];
        end else if (out_free) begin
          res_ld  = 1'b1;
          wr_en   = 1'b1;
          cnt_nxt = cnt_p1;
        end
      end
      BK_RD_FIRST: begin
        if (fold.hit) begin
          wr_en   = 1'b1;
          wr_addr = cnt_m2[AW-1:0];
          wr_data = fold.code;
        end else if (out_free) begin
          res_ld  = 1'b1;
          wr_en   = 1'b1;
          cnt_nxt = cnt_p1;
        end
      end
      BK_WR_MID: begin
        wr_en   = 1'b1;
        wr_addr = cnt_m1[AW-1:0];
        wr_data = CODE_EMPTY;
      end
      BK_WR_LAST: begin
        // clear the slot of the new entry and shrink the path by one: first, back and new fold into one
        if (out_free) begin
          wr_en   = 1'b1;
          wr_data = CODE_EMPTY;
          res_ld  = 1'b1;
          cnt_nxt = cnt_m1;
        end
      end
      BK_REPLAY: begin
        if (out_free) begin
          res_ld  = 1'b1;
          res_cmd = replay_cmd(rd_data_r);
          cnt_nxt = cnt_p1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (res_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_ld) op_r <= q_item;
    if (res_ld) begin
      cmd_r    <= res_cmd;
      plen_r   <= cnt_nxt;
      at_end_r <= res_end;
      ovf_r    <= res_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.motor_cmd     = cmd_r;
  assign out_ch.path_length   = plen_r;
  assign out_ch.at_end        = at_end_r;
  assign out_ch.path_overflow = ovf_r;

endmodule

`default_nettype wire
